[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the n-body step core
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

[design/nbge_pkg.sv]
// ----------------------------------------------------------------------------
// nbge_pkg
// Types, constants and Q16.48 helper functions for the n-body step core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nbge_pkg;

    localparam int MAX_BODIES = 64;
    localparam int ADDR_W     = $clog2(MAX_BODIES);
    localparam int CNT_W      = $clog2(MAX_BODIES + 1);

    typedef logic [63:0]  word_t;
    typedef logic [127:0] wide_t;

    // input actions
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_STEP = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_BODY_COUNT = 2'd0;
    localparam logic [1:0] CFG_TIME_STEP  = 2'd1;
    localparam logic [1:0] CFG_GRAV_CONST = 2'd2;

    localparam logic [6:0]  RST_BODY_COUNT = 7'd64;
    localparam logic [62:0] RST_TIME_STEP  = 63'd1099511627776;
    localparam logic [62:0] RST_GRAV_CONST = 63'd18783;

    localparam word_t Q_MAX = {1'b0, {63{1'b1}}};
    localparam word_t Q_MIN = {1'b1, {63{1'b0}}};

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_RD_EMIT,
        ST_I_RD,
        ST_I_LAT,
        ST_J_RD,
        ST_J_LAT,
        ST_SQX_GO,
        ST_SQX_W,
        ST_SQY_GO,
        ST_SQY_W,
        ST_RT_GO,
        ST_RT_W,
        ST_DV_GO,
        ST_DV_W,
        ST_MX_GO,
        ST_MX_W,
        ST_MY_GO,
        ST_MY_W,
        ST_GX_GO,
        ST_GX_W,
        ST_GY_GO,
        ST_GY_W,
        ST_A_WR,
        ST_U_RD,
        ST_U_LAT,
        ST_UVX_GO,
        ST_UVX_W,
        ST_UVY_GO,
        ST_UVY_W,
        ST_UPX_GO,
        ST_UPX_W,
        ST_UPY_GO,
        ST_UPY_W,
        ST_U_WR,
        ST_U_EMIT
    } state_t;

    // magnitude of a signed word
    function automatic word_t mag(input word_t a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

    // signed word from sign and magnitude, saturated
    function automatic word_t from_mag(input logic neg, input word_t m);
        if (neg)
        begin
            if (m[63])
                return Q_MIN;
            return 64'd0 - m;
        end
        if (m[63])
            return Q_MAX;
        return m;
    endfunction

    // saturating add
    function automatic word_t sadd(input word_t a, input word_t b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? Q_MIN : Q_MAX;
        return s[63:0];
    endfunction

    // saturating subtract
    function automatic word_t ssub(input word_t a, input word_t b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
            return s[64] ? Q_MIN : Q_MAX;
        return s[63:0];
    endfunction

    // finish a Q16.48 product from the magnitude product and its sign
    function automatic word_t qfin(input wide_t p, input logic neg);
        word_t m;
        m = (|p[127:112]) ? {64{1'b1}} : p[111:48];
        return from_mag(neg, m);
    endfunction

endpackage

[design/nbge_ram.sv]
// ----------------------------------------------------------------------------
// nbge_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbge_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

[design/nbge_mul.sv]
// ----------------------------------------------------------------------------
// nbge_mul
// 64x64 unsigned multiplier built from four 32x32 partial products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbge_mul (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  nbge_pkg::word_t      a,
    input  nbge_pkg::word_t      b,
    output logic                 done,
    output nbge_pkg::wide_t      prod
);

    nbge_pkg::word_t a_reg;
    nbge_pkg::word_t b_reg;
    nbge_pkg::wide_t acc_reg;
    logic [1:0]      cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [63:0]     pp;
    nbge_pkg::wide_t addend;

    // partial product for the current pair of halves
    always_comb
    begin
        pp = (cnt_reg[1] ? a_reg[63:32] : a_reg[31:0])
           * (cnt_reg[0] ? b_reg[63:32] : b_reg[31:0]);
        case (cnt_reg)
            2'd0:    addend = {64'd0, pp};
            2'd3:    addend = {pp, 64'd0};
            default: addend = {32'd0, pp, 32'd0};
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
            acc_reg <= acc_reg + addend;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

[design/nbge_sqrt.sv]
// ----------------------------------------------------------------------------
// nbge_sqrt
// Floor square root of a 128-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbge_sqrt (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  nbge_pkg::wide_t rad,
    output logic            done,
    output nbge_pkg::word_t root
);

    nbge_pkg::wide_t rad_reg;
    logic [66:0]     rem_reg;
    nbge_pkg::word_t root_reg;
    logic [5:0]      cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [66:0]     rem_sh;
    logic [66:0]     trial;
    logic            ge;

    // restoring step: bring down two bits, try root*4+1
    always_comb
    begin
        rem_sh = {rem_reg[64:0], rad_reg[127:126]};
        trial  = {1'b0, root_reg, 2'b01};
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[125:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[62:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[design/nbge_div.sv]
// ----------------------------------------------------------------------------
// nbge_div
// Q16.48 quotient floor(a * 2^48 / d), saturated, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbge_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  nbge_pkg::word_t a,
    input  nbge_pkg::word_t d,
    output logic            done,
    output nbge_pkg::word_t quot
);

    logic [63:0]     rem_reg;
    logic [62:0]     sh_reg;
    logic [62:0]     q_reg;
    nbge_pkg::word_t d_reg;
    logic [5:0]      cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic            sat;
    logic [64:0]     rem_sh;
    logic [64:0]     diff;
    logic            ge;

    // quotient overflows when a / d reaches 2^15
    assign sat = ({15'd0, a[63:15]} >= d);

    always_comb
    begin
        rem_sh = {rem_reg, sh_reg[62]};
        diff   = rem_sh - {1'b0, d_reg};
        ge     = (rem_sh >= {1'b0, d_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= 6'd0;
                if (sat)
                    done_reg <= 1'b1;
                else
                    busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd62)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg   <= d;
            rem_reg <= {15'd0, a[63:15]};
            sh_reg  <= {a[14:0], 48'd0};
            q_reg   <= sat ? {63{1'b1}} : 63'd0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[63:0] : rem_sh[63:0];
            sh_reg  <= {sh_reg[61:0], 1'b0};
            q_reg   <= {q_reg[61:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = {1'b0, q_reg};

endmodule

[design/nbody_gravity_euler_step_core.sv]
// ----------------------------------------------------------------------------
// nbody_gravity_euler_step_core
// Direct-sum 2D gravity with an explicit Euler step in Q16.48 fixed point.
// ----------------------------------------------------------------------------
// Body state sits in per-field synchronous RAMs; one sequencer shares a
// multiplier, a square root unit and a divider. A step visits every
// ordered pair of distinct bodies (square root plus three divides
// dominate; coincident pairs skip them), then updates and reports each
// body. Results leave through an output register; one transaction is
// worked on at a time. Body entries never loaded read back as undefined.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module nbody_gravity_euler_step_core (
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [199:0] s_tdata,   // body_index, load_x, load_y, load_mass
    input  logic [1:0]   s_tuser,   // action
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [263:0] m_tdata,   // out_index, out_x, out_y, out_vx, out_vy
    output logic         m_tlast,
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    localparam int AW = nbge_pkg::ADDR_W;
    localparam int CW = nbge_pkg::CNT_W;

    nbge_pkg::state_t state_reg, state_next;

    // configuration
    logic [6:0]      body_count_reg;
    logic [62:0]     time_step_reg;
    logic [62:0]     grav_const_reg;

    // sequencing
    logic [CW-1:0]   i_reg, j_reg, n_reg, n_calc, i_inc;
    logic [1:0]      dv_cnt_reg;
    logic [5:0]      idx_reg;
    logic            rng_reg;

    // datapath
    nbge_pkg::word_t xi_reg, yi_reg, dx_reg, dy_reg, m_reg, d_reg, q_reg;
    nbge_pkg::word_t sx_reg, sy_reg, ax_reg, ay_reg;
    nbge_pkg::word_t px_reg, py_reg, vx_reg, vy_reg;
    nbge_pkg::wide_t sq_reg, s_reg, s_sum;
    logic            neg_reg;

    // output register
    logic            m_tvalid_reg;
    logic [263:0]    m_tdata_reg;
    logic            m_tlast_reg;

    // input fields
    logic [5:0]      in_idx;
    nbge_pkg::word_t in_x, in_y;
    logic [62:0]     in_mass;
    logic            in_range, s_accept, out_free, last_i;

    // unit handshakes
    logic            mul_start, mul_done, mul_neg;
    nbge_pkg::word_t mul_a, mul_b;
    nbge_pkg::wide_t mul_prod;
    logic            sqrt_start, sqrt_done;
    nbge_pkg::word_t sqrt_root;
    logic            div_start, div_done;
    nbge_pkg::word_t div_quot;

    // memory ports
    logic            wr_ld, wr_a, wr_u, out_load;
    logic [AW-1:0]   rd_addr, wr_addr;
    nbge_pkg::word_t px_rd, py_rd, m_rd, vx_rd, vy_rd, ax_rd, ay_rd;

    // state groups used by the checks
    logic            body_st, mul_wait_st;

    assign in_idx   = s_tdata[5:0];
    assign in_x     = s_tdata[69:6];
    assign in_y     = s_tdata[133:70];
    assign in_mass  = s_tdata[196:134];
    assign in_range = ({1'b0, in_idx} < 7'(nbge_pkg::MAX_BODIES));

    assign s_tready  = (state_reg == nbge_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign i_inc     = i_reg + CW'(1);
    assign last_i    = (i_inc == n_reg);
    assign s_sum     = sq_reg + mul_prod;
    assign n_calc    = (body_count_reg > 7'(nbge_pkg::MAX_BODIES))
                     ? CW'(nbge_pkg::MAX_BODIES) : CW'(body_count_reg);

    // arithmetic units
    nbge_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    nbge_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (s_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    nbge_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (q_reg),
        .d     (d_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // body state memories
    nbge_ram #(.WIDTH(64), .DEPTH(nbge_pkg::MAX_BODIES)) u_px (
        .clk(clk), .wr_en(wr_ld || wr_u), .wr_addr(wr_addr),
        .wr_data(wr_ld ? in_x : px_reg), .rd_addr(rd_addr), .rd_data(px_rd));

    nbge_ram #(.WIDTH(64), .DEPTH(nbge_pkg::MAX_BODIES)) u_py (
        .clk(clk), .wr_en(wr_ld || wr_u), .wr_addr(wr_addr),
        .wr_data(wr_ld ? in_y : py_reg), .rd_addr(rd_addr), .rd_data(py_rd));

    nbge_ram #(.WIDTH(64), .DEPTH(nbge_pkg::MAX_BODIES)) u_m (
        .clk(clk), .wr_en(wr_ld), .wr_addr(wr_addr),
        .wr_data({1'b0, in_mass}), .rd_addr(rd_addr), .rd_data(m_rd));

    nbge_ram #(.WIDTH(64), .DEPTH(nbge_pkg::MAX_BODIES)) u_vx (
        .clk(clk), .wr_en(wr_ld || wr_u), .wr_addr(wr_addr),
        .wr_data(wr_ld ? 64'd0 : vx_reg), .rd_addr(rd_addr), .rd_data(vx_rd));

    nbge_ram #(.WIDTH(64), .DEPTH(nbge_pkg::MAX_BODIES)) u_vy (
        .clk(clk), .wr_en(wr_ld || wr_u), .wr_addr(wr_addr),
        .wr_data(wr_ld ? 64'd0 : vy_reg), .rd_addr(rd_addr), .rd_data(vy_rd));

    nbge_ram #(.WIDTH(64), .DEPTH(nbge_pkg::MAX_BODIES)) u_ax (
        .clk(clk), .wr_en(wr_ld || wr_a), .wr_addr(wr_addr),
        .wr_data(wr_ld ? 64'd0 : ax_reg), .rd_addr(rd_addr), .rd_data(ax_rd));

    nbge_ram #(.WIDTH(64), .DEPTH(nbge_pkg::MAX_BODIES)) u_ay (
        .clk(clk), .wr_en(wr_ld || wr_a), .wr_addr(wr_addr),
        .wr_data(wr_ld ? 64'd0 : ay_reg), .rd_addr(rd_addr), .rd_data(ay_rd));

    assign wr_addr = wr_ld ? in_idx[AW-1:0] : i_reg[AW-1:0];

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= nbge_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and unit controls
    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        mul_neg    = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        wr_ld      = 1'b0;
        wr_a       = 1'b0;
        wr_u       = 1'b0;
        rd_addr    = j_reg[AW-1:0];
        unique case (state_reg)
            nbge_pkg::ST_IDLE:
            begin
                rd_addr = in_idx[AW-1:0];
                if (s_accept)
                begin
                    case (s_tuser)
                        nbge_pkg::ACT_LOAD: wr_ld = in_range;
                        nbge_pkg::ACT_STEP:
                            if (n_calc != '0)
                                state_next = nbge_pkg::ST_I_RD;
                        nbge_pkg::ACT_READ: state_next = nbge_pkg::ST_RD_WAIT;
                        default: ;
                    endcase
                end
            end
            nbge_pkg::ST_RD_WAIT: state_next = nbge_pkg::ST_RD_EMIT;
            nbge_pkg::ST_RD_EMIT:
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = nbge_pkg::ST_IDLE;
                end
            // acceleration phase
            nbge_pkg::ST_I_RD:
            begin
                rd_addr    = i_reg[AW-1:0];
                state_next = nbge_pkg::ST_I_LAT;
            end
            nbge_pkg::ST_I_LAT: state_next = nbge_pkg::ST_J_RD;
            nbge_pkg::ST_J_RD:
                if (j_reg == n_reg)
                    state_next = nbge_pkg::ST_GX_GO;
                else if (j_reg != i_reg)
                    state_next = nbge_pkg::ST_J_LAT;
            nbge_pkg::ST_J_LAT: state_next = nbge_pkg::ST_SQX_GO;
            nbge_pkg::ST_SQX_GO:
            begin
                mul_start  = 1'b1;
                mul_a      = nbge_pkg::mag(dx_reg);
                mul_b      = nbge_pkg::mag(dx_reg);
                state_next = nbge_pkg::ST_SQX_W;
            end
            nbge_pkg::ST_SQX_W:
                if (mul_done)
                    state_next = nbge_pkg::ST_SQY_GO;
            nbge_pkg::ST_SQY_GO:
            begin
                mul_start  = 1'b1;
                mul_a      = nbge_pkg::mag(dy_reg);
                mul_b      = nbge_pkg::mag(dy_reg);
                state_next = nbge_pkg::ST_SQY_W;
            end
            nbge_pkg::ST_SQY_W:
                if (mul_done)
                    state_next = (s_sum == '0) ? nbge_pkg::ST_J_RD : nbge_pkg::ST_RT_GO;
            nbge_pkg::ST_RT_GO:
            begin
                sqrt_start = 1'b1;
                state_next = nbge_pkg::ST_RT_W;
            end
            nbge_pkg::ST_RT_W:
                if (sqrt_done)
                    state_next = nbge_pkg::ST_DV_GO;
            nbge_pkg::ST_DV_GO:
            begin
                div_start  = 1'b1;
                state_next = nbge_pkg::ST_DV_W;
            end
            nbge_pkg::ST_DV_W:
                if (div_done)
                    state_next = (dv_cnt_reg == 2'd2) ? nbge_pkg::ST_MX_GO
                                                      : nbge_pkg::ST_DV_GO;
            nbge_pkg::ST_MX_GO:
            begin
                mul_start  = 1'b1;
                mul_a      = q_reg;
                mul_b      = nbge_pkg::mag(dx_reg);
                mul_neg    = dx_reg[63];
                state_next = nbge_pkg::ST_MX_W;
            end
            nbge_pkg::ST_MX_W:
                if (mul_done)
                    state_next = nbge_pkg::ST_MY_GO;
            nbge_pkg::ST_MY_GO:
            begin
                mul_start  = 1'b1;
                mul_a      = q_reg;
                mul_b      = nbge_pkg::mag(dy_reg);
                mul_neg    = dy_reg[63];
                state_next = nbge_pkg::ST_MY_W;
            end
            nbge_pkg::ST_MY_W:
                if (mul_done)
                    state_next = nbge_pkg::ST_J_RD;
            nbge_pkg::ST_GX_GO:
            begin
                mul_start  = 1'b1;
                mul_a      = {1'b0, grav_const_reg};
                mul_b      = nbge_pkg::mag(sx_reg);
                mul_neg    = sx_reg[63];
                state_next = nbge_pkg::ST_GX_W;
            end
            nbge_pkg::ST_GX_W:
                if (mul_done)
                    state_next = nbge_pkg::ST_GY_GO;
            nbge_pkg::ST_GY_GO:
            begin
                mul_start  = 1'b1;
                mul_a      = {1'b0, grav_const_reg};
                mul_b      = nbge_pkg::mag(sy_reg);
                mul_neg    = sy_reg[63];
                state_next = nbge_pkg::ST_GY_W;
            end
            nbge_pkg::ST_GY_W:
                if (mul_done)
                    state_next = nbge_pkg::ST_A_WR;
            nbge_pkg::ST_A_WR:
            begin
                wr_a       = 1'b1;
                state_next = last_i ? nbge_pkg::ST_U_RD : nbge_pkg::ST_I_RD;
            end
            // update phase
            nbge_pkg::ST_U_RD:
            begin
                rd_addr    = i_reg[AW-1:0];
                state_next = nbge_pkg::ST_U_LAT;
            end
            nbge_pkg::ST_U_LAT: state_next = nbge_pkg::ST_UVX_GO;
            nbge_pkg::ST_UVX_GO:
            begin
                mul_start  = 1'b1;
                mul_a      = {1'b0, time_step_reg};
                mul_b      = nbge_pkg::mag(ax_reg);
                mul_neg    = ax_reg[63];
                state_next = nbge_pkg::ST_UVX_W;
            end
            nbge_pkg::ST_UVX_W:
                if (mul_done)
                    state_next = nbge_pkg::ST_UVY_GO;
            nbge_pkg::ST_UVY_GO:
            begin
                mul_start  = 1'b1;
                mul_a      = {1'b0, time_step_reg};
                mul_b      = nbge_pkg::mag(ay_reg);
                mul_neg    = ay_reg[63];
                state_next = nbge_pkg::ST_UVY_W;
            end
            nbge_pkg::ST_UVY_W:
                if (mul_done)
                    state_next = nbge_pkg::ST_UPX_GO;
            nbge_pkg::ST_UPX_GO:
            begin
                mul_start  = 1'b1;
                mul_a      = {1'b0, time_step_reg};
                mul_b      = nbge_pkg::mag(vx_reg);
                mul_neg    = vx_reg[63];
                state_next = nbge_pkg::ST_UPX_W;
            end
            nbge_pkg::ST_UPX_W:
                if (mul_done)
                    state_next = nbge_pkg::ST_UPY_GO;
            nbge_pkg::ST_UPY_GO:
            begin
                mul_start  = 1'b1;
                mul_a      = {1'b0, time_step_reg};
                mul_b      = nbge_pkg::mag(vy_reg);
                mul_neg    = vy_reg[63];
                state_next = nbge_pkg::ST_UPY_W;
            end
            nbge_pkg::ST_UPY_W:
                if (mul_done)
                    state_next = nbge_pkg::ST_U_WR;
            nbge_pkg::ST_U_WR:
            begin
                wr_u       = 1'b1;
                state_next = nbge_pkg::ST_U_EMIT;
            end
            nbge_pkg::ST_U_EMIT:
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = last_i ? nbge_pkg::ST_IDLE : nbge_pkg::ST_U_RD;
                end
            default: state_next = nbge_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_count_reg <= nbge_pkg::RST_BODY_COUNT;
            time_step_reg  <= nbge_pkg::RST_TIME_STEP;
            grav_const_reg <= nbge_pkg::RST_GRAV_CONST;
            i_reg          <= '0;
            j_reg          <= '0;
            n_reg          <= '0;
            dv_cnt_reg     <= 2'd0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            // configuration transaction
            if (cfg_valid)
            begin
                case (cfg_index)
                    nbge_pkg::CFG_BODY_COUNT: body_count_reg <= cfg_data[6:0];
                    nbge_pkg::CFG_TIME_STEP:  time_step_reg  <= cfg_data[62:0];
                    nbge_pkg::CFG_GRAV_CONST: grav_const_reg <= cfg_data[62:0];
                    default: ;
                endcase
            end

            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                nbge_pkg::ST_IDLE:
                    if (s_accept && s_tuser == nbge_pkg::ACT_STEP)
                    begin
                        n_reg <= n_calc;
                        i_reg <= '0;
                    end
                nbge_pkg::ST_I_LAT: j_reg <= '0;
                nbge_pkg::ST_J_RD:
                    if (j_reg != n_reg && j_reg == i_reg)
                        j_reg <= j_reg + CW'(1);
                nbge_pkg::ST_SQY_W:
                    if (mul_done && s_sum == '0)
                        j_reg <= j_reg + CW'(1);
                nbge_pkg::ST_MY_W:
                    if (mul_done)
                        j_reg <= j_reg + CW'(1);
                nbge_pkg::ST_RT_W:
                    if (sqrt_done)
                        dv_cnt_reg <= 2'd0;
                nbge_pkg::ST_DV_W:
                    if (div_done)
                        dv_cnt_reg <= dv_cnt_reg + 2'd1;
                nbge_pkg::ST_A_WR: i_reg <= last_i ? '0 : i_inc;
                nbge_pkg::ST_U_EMIT:
                    if (out_free && !last_i)
                        i_reg <= i_inc;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (mul_start)
            neg_reg <= mul_neg;

        case (state_reg)
            nbge_pkg::ST_IDLE:
                if (s_accept)
                begin
                    idx_reg <= in_idx;
                    rng_reg <= in_range;
                end
            nbge_pkg::ST_RD_WAIT:
            begin
                px_reg <= px_rd;
                py_reg <= py_rd;
                vx_reg <= vx_rd;
                vy_reg <= vy_rd;
            end
            nbge_pkg::ST_I_LAT:
            begin
                xi_reg <= px_rd;
                yi_reg <= py_rd;
                sx_reg <= '0;
                sy_reg <= '0;
            end
            nbge_pkg::ST_J_LAT:
            begin
                dx_reg <= nbge_pkg::ssub(px_rd, xi_reg);
                dy_reg <= nbge_pkg::ssub(py_rd, yi_reg);
                m_reg  <= m_rd;
            end
            nbge_pkg::ST_SQX_W: if (mul_done) sq_reg <= mul_prod;
            nbge_pkg::ST_SQY_W: if (mul_done) s_reg <= s_sum;
            nbge_pkg::ST_RT_W:
                if (sqrt_done)
                begin
                    d_reg <= sqrt_root;
                    q_reg <= m_reg;
                end
            nbge_pkg::ST_DV_W: if (div_done) q_reg <= div_quot;
            nbge_pkg::ST_MX_W:
                if (mul_done)
                    sx_reg <= nbge_pkg::sadd(sx_reg, nbge_pkg::qfin(mul_prod, neg_reg));
            nbge_pkg::ST_MY_W:
                if (mul_done)
                    sy_reg <= nbge_pkg::sadd(sy_reg, nbge_pkg::qfin(mul_prod, neg_reg));
            nbge_pkg::ST_GX_W: if (mul_done) ax_reg <= nbge_pkg::qfin(mul_prod, neg_reg);
            nbge_pkg::ST_GY_W: if (mul_done) ay_reg <= nbge_pkg::qfin(mul_prod, neg_reg);
            nbge_pkg::ST_U_LAT:
            begin
                px_reg <= px_rd;
                py_reg <= py_rd;
                vx_reg <= vx_rd;
                vy_reg <= vy_rd;
                ax_reg <= ax_rd;
                ay_reg <= ay_rd;
            end
            nbge_pkg::ST_UVX_W:
                if (mul_done)
                    vx_reg <= nbge_pkg::sadd(vx_reg, nbge_pkg::qfin(mul_prod, neg_reg));
            nbge_pkg::ST_UVY_W:
                if (mul_done)
                    vy_reg <= nbge_pkg::sadd(vy_reg, nbge_pkg::qfin(mul_prod, neg_reg));
            nbge_pkg::ST_UPX_W:
                if (mul_done)
                    px_reg <= nbge_pkg::sadd(px_reg, nbge_pkg::qfin(mul_prod, neg_reg));
            nbge_pkg::ST_UPY_W:
                if (mul_done)
                    py_reg <= nbge_pkg::sadd(py_reg, nbge_pkg::qfin(mul_prod, neg_reg));
            default: ;
        endcase

        // result register
        if (out_load)
        begin
            if (state_reg == nbge_pkg::ST_RD_EMIT)
            begin
                m_tlast_reg <= 1'b1;
                if (rng_reg)
                    m_tdata_reg <= {2'b00, vy_reg, vx_reg, py_reg, px_reg, idx_reg};
                else
                    m_tdata_reg <= {2'b00, 256'd0, idx_reg};
            end
            else
            begin
                m_tlast_reg <= last_i;
                m_tdata_reg <= {2'b00, vy_reg, vx_reg, py_reg, px_reg,
                                6'(i_reg[AW-1:0])};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // states that name a body below the count, and states that wait on the multiplier
    assign body_st     = (state_reg == nbge_pkg::ST_A_WR) || (state_reg == nbge_pkg::ST_U_EMIT);
    assign mul_wait_st = (state_reg == nbge_pkg::ST_SQX_W) || (state_reg == nbge_pkg::ST_SQY_W)
                      || (state_reg == nbge_pkg::ST_MX_W)  || (state_reg == nbge_pkg::ST_MY_W)
                      || (state_reg == nbge_pkg::ST_GX_W)  || (state_reg == nbge_pkg::ST_GY_W)
                      || (state_reg == nbge_pkg::ST_UVX_W) || (state_reg == nbge_pkg::ST_UVY_W)
                      || (state_reg == nbge_pkg::ST_UPX_W) || (state_reg == nbge_pkg::ST_UPY_W);

    // checks
    `AST_IMPL(a_div_nonzero, state_reg == nbge_pkg::ST_DV_GO, d_reg != '0)
    `AST_IMPL(a_body_in_range, body_st, i_reg < n_reg)
    `AST_IMPL(a_load_free, out_load && !m_tready, !m_tvalid_reg)
    `AST_IMPL(a_mul_waited, mul_done, mul_wait_st)

endmodule

[tb/tb_nbody_gravity_euler_step_core.sv]
// ----------------------------------------------------------------------------
// tb_nbody_gravity_euler_step_core
// Self-checking bench for the n-body gravity step core: loads, steps and
// reads are streamed in, each result is checked against an in-bench Q16.48
// predictor, across several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nbody_gravity_euler_step_core;

    localparam logic [1:0]  ACT_NONE  = 2'd3;
    localparam logic [63:0] Q_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_MIN     = 64'h8000_0000_0000_0000;
    localparam int          NBODY     = 64;
    localparam int          SETTLE    = 400;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  idx;
        logic [63:0] x;
        logic [63:0] y;
        logic [62:0] mass;
    } request_t;

    typedef struct packed {
        logic [5:0]  idx;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] vx;
        logic [63:0] vy;
        logic        last;
    } body_report_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [199:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [263:0] m_tdata;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [63:0]  cfg_data;

    request_t     request_q[$];
    body_report_t report_q[$];
    logic         in_taken;
    logic         cfg_taken;
    int           idle_pct;
    int           stall_pct;
    int           errors;

    // predictor copy of registers and body store
    logic [6:0]   body_cnt;
    logic [62:0]  dt_q;
    logic [62:0]  grav_q;
    logic [63:0]  px[NBODY];
    logic [63:0]  py[NBODY];
    logic [63:0]  pm[NBODY];
    logic [63:0]  vxs[NBODY];
    logic [63:0]  vys[NBODY];
    logic [63:0]  axs[NBODY];
    logic [63:0]  ays[NBODY];

    nbody_gravity_euler_step_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------- Q16.48 arithmetic ----------------
    function automatic logic [63:0] abs_q(logic [63:0] a);
        return a[63] ? 64'd0 - a : a;
    endfunction

    function automatic logic [63:0] sat_q(logic neg, logic [63:0] m);
        if (neg)
            return m[63] ? Q_MIN : 64'd0 - m;
        return m[63] ? Q_MAX : m;
    endfunction

    function automatic logic [63:0] add_q(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? Q_MIN : Q_MAX;
        return s[63:0];
    endfunction

    function automatic logic [63:0] sub_q(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
            return s[64] ? Q_MIN : Q_MAX;
        return s[63:0];
    endfunction

    // product truncated toward zero, saturated
    function automatic logic [63:0] mul_q(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        logic [63:0]  m;
        p = {64'd0, abs_q(a)} * {64'd0, abs_q(b)};
        m = (|p[127:112]) ? {64{1'b1}} : p[111:48];
        return sat_q(a[63] ^ b[63], m);
    endfunction

    // floor(a * 2^48 / d), saturated to Q_MAX
    function automatic logic [63:0] div_q(logic [63:0] a, logic [63:0] d);
        logic [127:0] q;
        q = {16'd0, a, 48'd0} / {64'd0, d};
        if (q > {64'd0, Q_MAX})
            return Q_MAX;
        return q[63:0];
    endfunction

    function automatic logic [63:0] isqrt_q(logic [127:0] s);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= s)
                r = c;
        end
        return r;
    endfunction

    // ---------------- gravity step predictor ----------------
    function automatic void push_report(int i, logic last);
        body_report_t r;
        r.idx  = i[5:0];
        r.x    = px[i];
        r.y    = py[i];
        r.vx   = vxs[i];
        r.vy   = vys[i];
        r.last = last;
        report_q.push_back(r);
    endfunction

    function automatic void predict_step();
        int           n;
        logic [63:0]  sx, sy, dx, dy, ux, uy, d, q, dt;
        logic [127:0] s;
        n = (body_cnt > NBODY) ? NBODY : body_cnt;
        dt = {1'b0, dt_q};
        // accelerations from old positions
        for (int i = 0; i < n; i++)
        begin
            sx = '0;
            sy = '0;
            for (int j = 0; j < n; j++)
            begin
                if (j == i)
                    continue;
                dx = sub_q(px[j], px[i]);
                dy = sub_q(py[j], py[i]);
                ux = abs_q(dx);
                uy = abs_q(dy);
                s = {64'd0, ux} * {64'd0, ux} + {64'd0, uy} * {64'd0, uy};
                // coincident pair adds nothing
                if (s == '0)
                    continue;
                d = isqrt_q(s);
                q = div_q(div_q(div_q(pm[j], d), d), d);
                sx = add_q(sx, mul_q(q, dx));
                sy = add_q(sy, mul_q(q, dy));
            end
            axs[i] = mul_q({1'b0, grav_q}, sx);
            ays[i] = mul_q({1'b0, grav_q}, sy);
        end
        // Euler update and report
        for (int i = 0; i < n; i++)
        begin
            vxs[i] = add_q(vxs[i], mul_q(dt, axs[i]));
            vys[i] = add_q(vys[i], mul_q(dt, ays[i]));
            px[i]  = add_q(px[i], mul_q(dt, vxs[i]));
            py[i]  = add_q(py[i], mul_q(dt, vys[i]));
            push_report(i, i == n - 1);
        end
    endfunction

    function automatic void predict_request(request_t rq);
        if (rq.action == nbge_pkg::ACT_LOAD)
        begin
            px[rq.idx]  = rq.x;
            py[rq.idx]  = rq.y;
            pm[rq.idx]  = {1'b0, rq.mass};
            vxs[rq.idx] = '0;
            vys[rq.idx] = '0;
            axs[rq.idx] = '0;
            ays[rq.idx] = '0;
        end
        else if (rq.action == nbge_pkg::ACT_READ)
            push_report(rq.idx, 1'b1);
        else if (rq.action == nbge_pkg::ACT_STEP)
            predict_step();
    endfunction

    // ---------------- driver ----------------
    always @(negedge clk)
    begin : drive
        request_t rq;
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (request_q.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    rq = request_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'd0, rq.mass, rq.y, rq.x, rq.idx};
                    s_tuser  <= rq.action;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ---------------- monitor and checker ----------------
    always @(posedge clk)
    begin : monitor
        request_t     rq;
        body_report_t got;
        body_report_t want;
        in_taken  <= s_tvalid && s_tready;
        cfg_taken <= cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == nbge_pkg::CFG_BODY_COUNT)
                    body_cnt = cfg_data[6:0];
                else if (cfg_index == nbge_pkg::CFG_TIME_STEP)
                    dt_q = cfg_data[62:0];
                else if (cfg_index == nbge_pkg::CFG_GRAV_CONST)
                    grav_q = cfg_data[62:0];
            end
            if (s_tvalid && s_tready)
            begin
                rq.action = s_tuser;
                rq.idx    = s_tdata[5:0];
                rq.x      = s_tdata[69:6];
                rq.y      = s_tdata[133:70];
                rq.mass   = s_tdata[196:134];
                predict_request(rq);
            end
            if (m_tvalid && m_tready)
            begin
                got.idx  = m_tdata[5:0];
                got.x    = m_tdata[69:6];
                got.y    = m_tdata[133:70];
                got.vx   = m_tdata[197:134];
                got.vy   = m_tdata[261:198];
                got.last = m_tlast;
                if (report_q.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = report_q.pop_front();
                    if (got.idx != want.idx)
                        $display("%0t: out_index expected %0d actual %0d",
                                 $time, want.idx, got.idx);
                    if (got.x != want.x)
                        $display("%0t: out_x expected %h actual %h", $time, want.x, got.x);
                    if (got.y != want.y)
                        $display("%0t: out_y expected %h actual %h", $time, want.y, got.y);
                    if (got.vx != want.vx)
                        $display("%0t: out_vx expected %h actual %h",
                                 $time, want.vx, got.vx);
                    if (got.vy != want.vy)
                        $display("%0t: out_vy expected %h actual %h",
                                 $time, want.vy, got.vy);
                    if (got.last != want.last)
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, got.last);
                    if (got != want)
                        errors++;
                end
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic add_request(logic [1:0] act, logic [5:0] idx, logic [63:0] x,
                               logic [63:0] y, logic [62:0] mass);
        request_t rq;
        rq.action = act;
        rq.idx    = idx;
        rq.x      = x;
        rq.y      = y;
        rq.mass   = mass;
        request_q.push_back(rq);
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // position within about +-8 units, occasionally full range
    function automatic logic [63:0] rand_pos();
        logic [63:0] r;
        r = rand_word();
        if ($urandom_range(9) == 0)
            return r;
        return {{12{r[51]}}, r[51:0]};
    endfunction

    function automatic logic [62:0] rand_mass();
        logic [63:0] r;
        r = rand_word();
        if ($urandom_range(9) == 0)
            return r[62:0];
        return {11'd0, r[51:0]};
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [63:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        while (!cfg_taken)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait until all requests are sent and every result is back
    task automatic drain();
        @(posedge clk);
        while (request_q.size() > 0 || s_tvalid || report_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ---------------- main sequence ----------------
    initial
    begin : main
        logic [63:0] x2, y2;
        int          pick;
        int          cnt;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idle_pct  = 0;
        stall_pct = 0;
        errors    = 0;
        body_cnt  = nbge_pkg::RST_BODY_COUNT;
        dt_q      = nbge_pkg::RST_TIME_STEP;
        grav_q    = nbge_pkg::RST_GRAV_CONST;
        for (int i = 0; i < NBODY; i++)
        begin
            px[i] = '0; py[i] = '0; pm[i] = '0;
            vxs[i] = '0; vys[i] = '0; axs[i] = '0; ays[i] = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill the whole store; extremes and a coincident pair up front
        add_request(nbge_pkg::ACT_LOAD, 6'd0, Q_MIN, Q_MAX, Q_MAX[62:0]);
        add_request(nbge_pkg::ACT_LOAD, 6'd1, Q_MAX, Q_MIN, 63'd0);
        x2 = rand_pos();
        y2 = rand_pos();
        add_request(nbge_pkg::ACT_LOAD, 6'd2, x2, y2, rand_mass());
        add_request(nbge_pkg::ACT_LOAD, 6'd3, x2, y2, rand_mass());
        for (int i = 4; i < NBODY; i++)
            add_request(nbge_pkg::ACT_LOAD, i[5:0], rand_pos(), rand_pos(), rand_mass());
        add_request(nbge_pkg::ACT_READ, 6'd0, '0, '0, '0);
        add_request(nbge_pkg::ACT_READ, 6'd63, '0, '0, '0);
        add_request(ACT_NONE, 6'd5, rand_word(), rand_word(), rand_mass());
        drain();

        // count above the store size acts as a full store, reset dt and G
        write_reg(nbge_pkg::CFG_BODY_COUNT, 64'd127);
        add_request(nbge_pkg::ACT_STEP, 6'd0, '0, '0, '0);
        add_request(nbge_pkg::ACT_READ, 6'd1, '0, '0, '0);
        drain();

        // zero bodies: a step reports nothing
        write_reg(nbge_pkg::CFG_BODY_COUNT, 64'd0);
        add_request(nbge_pkg::ACT_STEP, 6'd0, '0, '0, '0);
        add_request(ACT_NONE, 6'd63, '0, '0, '0);
        add_request(nbge_pkg::ACT_READ, 6'd3, '0, '0, '0);
        drain();

        // random phases: each sets registers, then mixed traffic
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 72; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 72; end
                default: begin idle_pct = 6; stall_pct = 6; end
            endcase
            cnt = (ph == 0) ? 1 : $urandom_range(6, 2);
            write_reg(nbge_pkg::CFG_BODY_COUNT, 64'(cnt));
            if (ph == 0)
            begin
                write_reg(nbge_pkg::CFG_TIME_STEP, Q_MAX);
                write_reg(nbge_pkg::CFG_GRAV_CONST, Q_MAX);
            end
            else if (ph == 1)
            begin
                write_reg(nbge_pkg::CFG_TIME_STEP, 64'd0);
                write_reg(nbge_pkg::CFG_GRAV_CONST, 64'd0);
            end
            else
            begin
                write_reg(nbge_pkg::CFG_TIME_STEP,
                          {12'd0, 4'($urandom_range(15)), 16'd0, $urandom});
                write_reg(nbge_pkg::CFG_GRAV_CONST, rand_word() >> $urandom_range(63));
            end
            for (int k = 0; k < 7; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    add_request(nbge_pkg::ACT_STEP, 6'($urandom), rand_word(), rand_word(),
                                rand_mass());
                else if (pick < 65)
                    add_request(nbge_pkg::ACT_LOAD, 6'($urandom_range(cnt - 1)), rand_pos(),
                                rand_pos(), rand_mass());
                else if (pick < 70)
                    add_request(nbge_pkg::ACT_LOAD, 6'($urandom_range(63)), rand_word(),
                                rand_word(), 63'(rand_word()));
                else if (pick < 95)
                    add_request(nbge_pkg::ACT_READ, 6'($urandom_range(63)), rand_word(),
                                rand_word(), rand_mass());
                else
                    add_request(ACT_NONE, 6'($urandom), rand_word(), rand_word(),
                                rand_mass());
            end
            drain();
        end

        if (errors == 0)
            $display("nbody_gravity_euler_step_core verification clean");
        else
            $display("nbody_gravity_euler_step_core verification failed");
        $finish;
    end

    // run limit
    initial
    begin
        #60_000_000;
        $display("nbody_gravity_euler_step_core verification failed");
        $finish;
    end

endmodule
